### rtl/srarq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srarq_pkg - shared types and constants
// Result kinds, the end-of-transfer marker and the frame event passed from
// the byte intake to the window sequencer.
// ----------------------------------------------------------------------------
package srarq_pkg;

    // Result kind carried on the kind port
    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_ACK  = 2'd1,
        KIND_NACK = 2'd2,
        KIND_END  = 2'd3
    } kind_t;

    // "$$END$$" plus a zero byte, first byte in the low bits
    localparam logic [63:0] END_MARKER_WORD = 64'h0024_2444_4E45_2424;

    localparam logic [7:0] CHECKSUM_GOOD = 8'hFF;

    // One pulse per completed frame
    typedef struct packed {
        logic valid;
        logic good;
        logic is_end;
    } frame_evt_t;

    // Window sequencer status seen by the intake and the top level
    typedef struct packed {
        logic busy;
        logic done;
    } win_status_t;

endpackage
`default_nettype wire

### rtl/srarq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srarq_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module srarq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

### rtl/srarq_frame_rx.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srarq_frame_rx - frame byte intake
// Tracks the byte position, folds the checksum, reduces the sequence byte
// by reciprocal multiplication, packs payload bytes into words written to the
// staging buffer, and flags the first zero byte and the end marker.
// ----------------------------------------------------------------------------
module srarq_frame_rx #(
    parameter int WINDOW        = 3,
    parameter int PAYLOAD_BYTES = 64
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     accept,
    input  wire logic [7:0]               frame_byte,
    input  wire logic                     end_around_carry,
    input  wire srarq_pkg::win_status_t   win_status,
    input  wire logic [$clog2(WINDOW+1)-1:0] stage_phys,
    output srarq_pkg::frame_evt_t         evt,
    output logic [$clog2(2*WINDOW+1)-1:0] evt_seq,
    output logic [$clog2(PAYLOAD_BYTES+1)-1:0] evt_zero,
    output logic                          wr_en,
    output logic [$clog2((WINDOW+1) * (2**((((PAYLOAD_BYTES+7)/8) > 1)
                          ? $clog2((PAYLOAD_BYTES+7)/8) : 1)))-1:0] wr_addr,
    output logic [63:0]                   wr_data
);

    localparam int SEQ_MOD = 2 * WINDOW + 1;
    localparam int SEQ_W   = $clog2(SEQ_MOD);
    localparam int WPS     = (PAYLOAD_BYTES + 7) / 8;
    localparam int WIDX    = (WPS > 1) ? $clog2(WPS) : 1;
    localparam int PW      = $clog2(PAYLOAD_BYTES + 2);
    localparam int ZW      = $clog2(PAYLOAD_BYTES + 1);
    // ceil(2^16 / SEQ_MOD): exact quotient for any 8-bit sequence byte
    localparam int RECIP   = (65536 + SEQ_MOD - 1) / SEQ_MOD;

    logic [PW-1:0]    pos_reg, pos_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       frame_seq_reg, frame_seq_next;
    logic [ZW-1:0]    zero_reg, zero_next;
    logic             end_reg, end_next;
    logic [63:0]      acc_reg, acc_next;

    srarq_pkg::frame_evt_t evt_reg, evt_next;
    logic [SEQ_W-1:0] evt_seq_reg, evt_seq_next;
    logic [ZW-1:0]    evt_zero_reg, evt_zero_next;

    logic             live;
    logic             is_seq_byte;
    logic             is_payload;
    logic [PW-1:0]    k;
    logic [2:0]       lane;
    logic [8:0]       raw_sum;
    logic [7:0]       folded;
    logic [23:0]      seq_prod;
    logic [7:0]       seq_quo;
    logic [11:0]      seq_back;
    logic [SEQ_W-1:0] seq_rem;
    logic [63:0]      lane_data;

    assign live        = accept && !win_status.done;
    assign is_seq_byte = (pos_reg == '0);
    assign is_payload  = !is_seq_byte && (pos_reg <= PW'(PAYLOAD_BYTES));
    assign k           = pos_reg - PW'(1);
    assign lane        = k[2:0];
    assign raw_sum     = {1'b0, sum_reg} + {1'b0, frame_byte};
    assign folded      = end_around_carry ? (raw_sum[7:0] + {7'd0, raw_sum[8]})
                                          : raw_sum[7:0];
    // sequence byte modulo SEQ_MOD
    assign seq_prod    = 24'(frame_seq_reg) * 24'(RECIP);
    assign seq_quo     = seq_prod[23:16];
    assign seq_back    = 12'(seq_quo) * 12'(SEQ_MOD);
    assign seq_rem     = SEQ_W'(12'(frame_seq_reg) - seq_back);
    assign lane_data   = {56'd0, frame_byte} << {lane, 3'b000};

    always_comb
    begin
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        frame_seq_next = frame_seq_reg;
        zero_next      = zero_reg;
        end_next       = end_reg;
        acc_next       = acc_reg;
        evt_next       = '0;
        evt_seq_next   = evt_seq_reg;
        evt_zero_next  = evt_zero_reg;
        wr_en          = 1'b0;
        if (live)
        begin
            if (is_seq_byte)
            begin
                frame_seq_next = frame_byte;
                sum_next       = '0;
                zero_next      = ZW'(PAYLOAD_BYTES);
                end_next       = 1'b1;
                pos_next       = PW'(1);
            end
            else
            begin
                sum_next = folded;
                if (is_payload)
                begin
                    if (k < PW'(8))
                    begin
                        if (frame_byte != srarq_pkg::END_MARKER_WORD[{lane, 3'b000} +: 8])
                        begin
                            end_next = 1'b0;
                        end
                    end
                    if ((frame_byte == 8'd0) && (zero_reg == ZW'(PAYLOAD_BYTES)))
                    begin
                        zero_next = ZW'(k);
                    end
                    acc_next = (lane == 3'd0) ? lane_data : (acc_reg | lane_data);
                    if ((lane == 3'd7) || (k == PW'(PAYLOAD_BYTES - 1)))
                    begin
                        wr_en = 1'b1;
                    end
                    pos_next = pos_reg + PW'(1);
                end
                else
                begin
                    evt_next.valid = 1'b1;
                    evt_next.good  = (folded == srarq_pkg::CHECKSUM_GOOD);
                    evt_next.is_end = end_reg;
                    evt_seq_next   = seq_rem;
                    evt_zero_next  = zero_reg;
                    pos_next       = '0;
                end
            end
        end
    end

    assign wr_addr  = {stage_phys, WIDX'(k >> 3)};
    assign wr_data  = acc_next;
    assign evt      = evt_reg;
    assign evt_seq  = evt_seq_reg;
    assign evt_zero = evt_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            sum_reg <= '0;
            evt_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
            evt_reg <= evt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_seq_reg <= frame_seq_next;
        zero_reg      <= zero_next;
        end_reg       <= end_next;
        acc_reg       <= acc_next;
        evt_seq_reg   <= evt_seq_next;
        evt_zero_reg  <= evt_zero_next;
    end

endmodule
`default_nettype wire

### rtl/srarq_window.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srarq_window - receive window and release sequencer
// Swaps the staging buffer of each good in-window frame into the slot map,
// then walks the leading filled slots, reading one word per memory access,
// and produces data, ack, nack and end results through an output register.
// ----------------------------------------------------------------------------
module srarq_window #(
    parameter int WINDOW        = 3,
    parameter int PAYLOAD_BYTES = 64
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire srarq_pkg::frame_evt_t    evt,
    input  wire logic [$clog2(2*WINDOW+1)-1:0] evt_seq,
    input  wire logic [$clog2(PAYLOAD_BYTES+1)-1:0] evt_zero,
    output srarq_pkg::win_status_t        win_status,
    output logic [$clog2(WINDOW+1)-1:0]   stage_phys,
    output logic [$clog2((WINDOW+1) * (2**((((PAYLOAD_BYTES+7)/8) > 1)
                          ? $clog2((PAYLOAD_BYTES+7)/8) : 1)))-1:0] rd_addr,
    input  wire logic [63:0]              rd_data,
    output logic                          result_valid,
    input  wire logic                     result_ready,
    output logic [1:0]                    kind,
    output logic [$clog2(2*WINDOW+1)-1:0] seq,
    output logic [63:0]                   data_word,
    output logic [3:0]                    bytes_valid,
    output logic                          last
);

    localparam int SEQ_MOD = 2 * WINDOW + 1;
    localparam int SEQ_W   = $clog2(SEQ_MOD);
    localparam int WPS     = (PAYLOAD_BYTES + 7) / 8;
    localparam int WIDX    = (WPS > 1) ? $clog2(WPS) : 1;
    localparam int PHW     = $clog2(WINDOW + 1);
    localparam int SLW     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int ZW      = $clog2(PAYLOAD_BYTES + 1);
    localparam int VW      = ZW + 4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_READ,
        S_WORD,
        S_REPLY,
        S_END,
        S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [SEQ_W-1:0]  front_seq_reg, front_seq_next;
    logic [SLW-1:0]    front_slot_reg, front_slot_next;
    logic [WINDOW-1:0] filled_reg, filled_next;
    logic [PHW-1:0]    map_reg [WINDOW];
    logic [PHW-1:0]    map_next [WINDOW];
    logic [PHW-1:0]    stage_reg, stage_next;
    logic [WIDX-1:0]   word_reg, word_next;
    logic [SEQ_W-1:0]  ack_seq_reg, ack_seq_next;

    logic              valid_reg, valid_next;
    srarq_pkg::kind_t  kind_reg, kind_next;
    logic [SEQ_W-1:0]  seq_reg, seq_next;
    logic [63:0]       data_reg, data_next;
    logic [3:0]        bv_reg, bv_next;
    logic              last_reg, last_next;

    logic [ZW-1:0]     meta_zero_reg [WINDOW+1];
    logic              meta_end_reg  [WINDOW+1];
    logic              meta_we;

    logic [SEQ_W:0]    off_sum;
    logic [SEQ_W-1:0]  off;
    logic [SLW:0]      slot_sum;
    logic [SLW-1:0]    slot;
    logic [PHW-1:0]    front_phys;
    logic [VW-1:0]     zpos;
    logic [VW-1:0]     base;
    logic [VW-1:0]     diff;
    logic [3:0]        word_bv;

    // window offset and target slot of the arriving frame
    assign off_sum  = {1'b0, evt_seq} + (SEQ_W+1)'(SEQ_MOD) - {1'b0, front_seq_reg};
    assign off      = (off_sum >= (SEQ_W+1)'(SEQ_MOD))
                    ? SEQ_W'(off_sum - (SEQ_W+1)'(SEQ_MOD)) : SEQ_W'(off_sum);
    assign slot_sum = {1'b0, front_slot_reg} + (SLW+1)'(off);
    assign slot     = (slot_sum >= (SLW+1)'(WINDOW))
                    ? SLW'(slot_sum - (SLW+1)'(WINDOW)) : SLW'(slot_sum);

    assign front_phys = map_reg[front_slot_reg];

    // bytes of the current word ahead of the slot's first zero byte
    assign zpos = VW'(meta_zero_reg[front_phys]);
    assign base = VW'({word_reg, 3'b000});
    assign diff = zpos - base;
    assign word_bv = (zpos <= base) ? 4'd0 : ((diff > VW'(8)) ? 4'd8 : diff[3:0]);

    always_comb
    begin
        state_next      = state_reg;
        front_seq_next  = front_seq_reg;
        front_slot_next = front_slot_reg;
        filled_next     = filled_reg;
        map_next        = map_reg;
        stage_next      = stage_reg;
        word_next       = word_reg;
        ack_seq_next    = ack_seq_reg;
        valid_next      = valid_reg;
        kind_next       = kind_reg;
        seq_next        = seq_reg;
        data_next       = data_reg;
        bv_next         = bv_reg;
        last_next       = last_reg;
        meta_we         = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (evt.valid)
                begin
                    ack_seq_next = evt_seq;
                    if (!evt.good)
                    begin
                        valid_next = 1'b1;
                        kind_next  = srarq_pkg::KIND_NACK;
                        seq_next   = evt_seq;
                        data_next  = '0;
                        bv_next    = '0;
                        last_next  = 1'b1;
                        state_next = S_REPLY;
                    end
                    else
                    begin
                        if (off < SEQ_W'(WINDOW))
                        begin
                            // swap the staging buffer into the slot
                            map_next[slot]    = stage_reg;
                            stage_next        = map_reg[slot];
                            filled_next[slot] = 1'b1;
                            meta_we           = 1'b1;
                        end
                        word_next  = '0;
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (filled_reg[front_slot_reg])
                begin
                    if (meta_end_reg[front_phys])
                    begin
                        valid_next = 1'b1;
                        kind_next  = srarq_pkg::KIND_END;
                        seq_next   = front_seq_reg;
                        data_next  = '0;
                        bv_next    = '0;
                        last_next  = 1'b1;
                        state_next = S_END;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
                else
                begin
                    valid_next = 1'b1;
                    kind_next  = srarq_pkg::KIND_ACK;
                    seq_next   = ack_seq_reg;
                    data_next  = '0;
                    bv_next    = '0;
                    last_next  = 1'b1;
                    state_next = S_REPLY;
                end
            end
            S_READ:
            begin
                valid_next = 1'b1;
                kind_next  = srarq_pkg::KIND_DATA;
                seq_next   = front_seq_reg;
                data_next  = rd_data;
                bv_next    = word_bv;
                last_next  = 1'b0;
                state_next = S_WORD;
            end
            S_WORD:
            begin
                if (result_ready)
                begin
                    valid_next = 1'b0;
                    if (word_reg == WIDX'(WPS - 1))
                    begin
                        filled_next[front_slot_reg] = 1'b0;
                        front_slot_next = (front_slot_reg == SLW'(WINDOW - 1))
                                        ? '0 : front_slot_reg + SLW'(1);
                        front_seq_next  = (front_seq_reg == SEQ_W'(SEQ_MOD - 1))
                                        ? '0 : front_seq_reg + SEQ_W'(1);
                        word_next       = '0;
                        state_next      = S_CHECK;
                    end
                    else
                    begin
                        word_next  = word_reg + WIDX'(1);
                        state_next = S_READ;
                    end
                end
            end
            S_REPLY:
            begin
                if (result_ready)
                begin
                    valid_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            S_END:
            begin
                if (result_ready)
                begin
                    valid_next = 1'b0;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_DONE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // read the word the sequencer will present next
    assign rd_addr = {front_phys, word_next};

    assign win_status.busy = (state_reg != S_IDLE) && (state_reg != S_DONE);
    assign win_status.done = (state_reg == S_DONE);
    assign stage_phys      = stage_reg;

    assign result_valid = valid_reg;
    assign kind         = kind_reg;
    assign seq          = seq_reg;
    assign data_word    = data_reg;
    assign bytes_valid  = bv_reg;
    assign last         = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            front_seq_reg  <= '0;
            front_slot_reg <= '0;
            filled_reg     <= '0;
            for (int i = 0; i < WINDOW; i++)
            begin
                map_reg[i] <= PHW'(i);
            end
            stage_reg      <= PHW'(WINDOW);
            word_reg       <= '0;
            ack_seq_reg    <= '0;
            valid_reg      <= 1'b0;
            kind_reg       <= srarq_pkg::KIND_DATA;
            seq_reg        <= '0;
            data_reg       <= '0;
            bv_reg         <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            front_seq_reg  <= front_seq_next;
            front_slot_reg <= front_slot_next;
            filled_reg     <= filled_next;
            map_reg        <= map_next;
            stage_reg      <= stage_next;
            word_reg       <= word_next;
            ack_seq_reg    <= ack_seq_next;
            valid_reg      <= valid_next;
            kind_reg       <= kind_next;
            seq_reg        <= seq_next;
            data_reg       <= data_next;
            bv_reg         <= bv_next;
            last_reg       <= last_next;
        end
    end

    // per-buffer frame summary, written when the buffer is committed
    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            meta_zero_reg[stage_reg] <= evt_zero;
            meta_end_reg[stage_reg]  <= evt.is_end;
        end
    end

endmodule
`default_nettype wire

### rtl/selective_repeat_arq_receiver_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// selective_repeat_arq_receiver_core - selective-repeat ARQ receiver
// Reassembles checksummed frames into a sliding receive window and releases
// completed slots in order as 64-bit words, with ACK, NACK and end results.
// ----------------------------------------------------------------------------
// A frame is one sequence byte, PAYLOAD_BYTES payload bytes and one checksum
// byte, taken one per cycle on the frame channel while frame_ready is high.
// Payload bytes are packed into words and written straight into a spare
// buffer of the slot memory; a good frame inside the window is committed by
// swapping that buffer into its slot, so no copy is made. After the checksum
// byte the block holds frame_ready low while it releases any ready slots,
// each read word by word (a memory read, then the word presented), and
// sends its ACK, NACK or end result, longer when result_ready stalls; a
// full release of WINDOW slots is WINDOW*ceil(PAYLOAD_BYTES/8) words.
// Between checksum bytes it takes one byte every cycle. The slot
// memory holds WINDOW+1 buffers and needs no clearing after reset, so the
// block is ready as soon as reset is released. Once the end marker has been
// seen, bytes are still taken but dropped, and no more results appear until
// reset. end_around_carry may be written only while no frame is in flight.
// ----------------------------------------------------------------------------
module selective_repeat_arq_receiver_core #(
    parameter int WINDOW        = 3,
    parameter int PAYLOAD_BYTES = 64,
    localparam int SEQ_W        = $clog2(2 * WINDOW + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    // configuration write channel
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic             cfg_data,
    // frame byte channel
    input  wire logic             frame_valid,
    output logic                  frame_ready,
    input  wire logic [7:0]       frame_byte,
    // result channel
    output logic                  result_valid,
    input  wire logic             result_ready,
    output logic [1:0]            kind,
    output logic [SEQ_W-1:0]      seq,
    output logic [63:0]           data_word,
    output logic [3:0]            bytes_valid,
    output logic                  last
);

    localparam int WPS   = (PAYLOAD_BYTES + 7) / 8;
    localparam int WIDX  = (WPS > 1) ? $clog2(WPS) : 1;
    localparam int PHW   = $clog2(WINDOW + 1);
    localparam int DEPTH = (WINDOW + 1) * (2 ** WIDX);
    localparam int AW    = $clog2(DEPTH);
    localparam int ZW    = $clog2(PAYLOAD_BYTES + 1);

    logic                   eac_reg, eac_next;
    logic                   frame_accept;

    srarq_pkg::frame_evt_t  evt;
    srarq_pkg::win_status_t win_status;
    logic [SEQ_W-1:0]       evt_seq;
    logic [ZW-1:0]          evt_zero;
    logic [PHW-1:0]         stage_phys;

    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [63:0]            wr_data;
    logic [AW-1:0]          rd_addr;
    logic [63:0]            rd_data;

    // Configuration: always ready, the register is a single bit
    assign cfg_ready = 1'b1;
    assign eac_next  = (cfg_valid && cfg_ready) ? cfg_data : eac_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eac_reg <= 1'b1;
        end
        else
        begin
            eac_reg <= eac_next;
        end
    end

    // Hold off bytes while a finished frame is being handled: the event
    // cycle itself and the whole reply sequence.
    assign frame_ready  = !evt.valid && !win_status.busy;
    assign frame_accept = frame_valid && frame_ready;

    srarq_frame_rx #(
        .WINDOW        (WINDOW),
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_frame_rx (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (frame_accept),
        .frame_byte       (frame_byte),
        .end_around_carry (eac_reg),
        .win_status       (win_status),
        .stage_phys       (stage_phys),
        .evt              (evt),
        .evt_seq          (evt_seq),
        .evt_zero         (evt_zero),
        .wr_en            (wr_en),
        .wr_addr          (wr_addr),
        .wr_data          (wr_data)
    );

    // Slot memory: WINDOW+1 buffers of one frame each, one word per row
    srarq_ram #(
        .WIDTH (64),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    srarq_window #(
        .WINDOW        (WINDOW),
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .evt          (evt),
        .evt_seq      (evt_seq),
        .evt_zero     (evt_zero),
        .win_status   (win_status),
        .stage_phys   (stage_phys),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .kind         (kind),
        .seq          (seq),
        .data_word    (data_word),
        .bytes_valid  (bytes_valid),
        .last         (last)
    );

endmodule
`default_nettype wire
